// ===== sv/sfp_pkg.sv =====
// ----------------------------------------------------------------------------
// sfp_pkg: shared constants for the sensor frame parser
// Frame layout, register indexes, reset values and arithmetic widths.
// ----------------------------------------------------------------------------
package sfp_pkg;

    localparam int PAYLOAD_BYTES = 20;
    localparam int POS_W         = 5;
    localparam logic [POS_W-1:0] POS_SEQ     = POS_W'(4);
    localparam logic [POS_W-1:0] POS_LEN     = POS_W'(5);
    localparam logic [POS_W-1:0] POS_PAYLOAD = POS_W'(6);
    localparam logic [POS_W-1:0] POS_CHECK   = POS_W'(6 + PAYLOAD_BYTES);
    localparam int IDX_W         = $clog2(PAYLOAD_BYTES);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_BYTE     = 3'd0,
        CFG_DEVICE_CODE    = 3'd1,
        CFG_SYSTEM_CODE    = 3'd2,
        CFG_MESSAGE_CODE   = 3'd3,
        CFG_FILTER_GAIN    = 3'd4,
        CFG_DISTANCE_SCALE = 3'd5,
        CFG_FLOW_SCALE     = 3'd6
    } t_cfg_idx;

    localparam logic [7:0]  RST_START_BYTE   = 8'd239;
    localparam logic [7:0]  RST_DEVICE_CODE  = 8'd15;
    localparam logic [7:0]  RST_SYSTEM_CODE  = 8'd0;
    localparam logic [7:0]  RST_MESSAGE_CODE = 8'd81;
    localparam logic [16:0] RST_FILTER_GAIN  = 17'd9830;
    localparam logic [23:0] RST_SCALE        = 24'd65536;
    localparam logic [16:0] GAIN_ONE         = 17'd65536;

    // serial multiplier: signed multiplicand A, unsigned multiplier B
    localparam int MA_W  = 50;
    localparam int MB_W  = 24;
    localparam int MH_W  = MA_W + 1;
    localparam int ACC_W = MH_W + MB_W;
    localparam int CNT_W = 5;
    localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);

    localparam int DIST_W = 48;
    localparam int FLOW_W = 40;

    typedef enum logic [1:0] {
        CH_DIST = 2'd0,
        CH_FX   = 2'd1,
        CH_FY   = 2'd2
    } t_chan;

endpackage

// ===== sv/sensor_frame_parser_iir_top.sv =====
// ----------------------------------------------------------------------------
// sensor_frame_parser_iir_top: byte-stream frame parser with smoothing filters
// Assembles sensor frames, checks the sum checksum, unpacks the fields and
// smooths scaled distance and flow through three exponential filters.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel: one received byte per item (i_in_valid / o_in_stall).
//  Output channel: one result item per checksum byte (o_out_valid /
//  i_out_stall); header or length mismatches give no result.
//  Header, sequence, length and payload bytes are taken even while a result
//  waits at the output register.
//  A checksum byte is held off while a result still waits. A bad checksum
//  sets its error result straight in the output register. A good one starts the
//  arithmetic: six passes of a shared shift-add multiplier that retires one
//  multiplier bit a cycle (24 bits), plus load and rounding steps. Input is
//  stalled until the result is registered.
//  A frame is 27 bytes long.
//  Reset (synchronous, active low) restores the register defaults, clears
//  the filter memories and returns the parser to start-byte hunting.
//  Configuration writes are taken at any time and act at once.
// ----------------------------------------------------------------------------
module sensor_frame_parser_iir_top
    import sfp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [7:0]            i_rx_byte,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_frame_status,
    output logic [31:0]           o_system_time,
    output logic [31:0]           o_raw_distance,
    output logic [7:0]            o_signal_strength,
    output logic [7:0]            o_distance_status,
    output logic signed [15:0]    o_raw_flow_x,
    output logic signed [15:0]    o_raw_flow_y,
    output logic [7:0]            o_flow_quality,
    output logic [7:0]            o_flow_status,
    output logic [DIST_W-1:0]     o_smoothed_distance,
    output logic signed [FLOW_W-1:0] o_smoothed_flow_x,
    output logic signed [FLOW_W-1:0] o_smoothed_flow_y
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN,
        ST_POST,
        ST_APPLY,
        ST_DONE
    } t_state;

    // configuration
    logic [7:0]  r_start_byte, r_device_code, r_system_code, r_message_code;
    logic [16:0] r_filter_gain;
    logic [23:0] r_distance_scale, r_flow_scale;

    // parser
    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_rsum, n_rsum;
    logic [7:0]       r_store [PAYLOAD_BYTES];
    logic             w_store, w_good, w_bad;

    // arithmetic
    t_state                  r_state;
    t_chan                   r_chan;
    logic                    r_filt;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [MA_W-1:0]  r_ma;
    logic signed [MH_W-1:0]  r_hi;
    logic [MB_W-1:0]         r_lo;
    logic signed [MA_W-1:0]  r_x;
    logic [DIST_W-1:0]       r_dmem;
    logic signed [FLOW_W-1:0] r_fxmem, r_fymem;
    logic                    r_busy;

    logic                    r_out_valid;

    logic                    in_acc, out_acc;
    logic [7:0]              rx, sum_add, hdr_want;
    logic [16:0]             geff;
    logic signed [MH_W-1:0]  n_sum;
    logic signed [MA_W-1:0]  mem_ext;
    logic [ACC_W-1:0]        prod, prod_rnd;
    logic signed [MA_W-1:0]  n_mem;
    logic signed [15:0]      raw_fx, raw_fy;

    assign rx       = i_rx_byte;
    assign o_in_stall = r_busy || (r_out_valid && (r_pos == POS_CHECK));
    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_acc  = r_out_valid && !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign sum_add  = r_rsum + rx;
    assign geff     = (r_filter_gain > GAIN_ONE) ? GAIN_ONE : r_filter_gain;
    assign raw_fx   = {r_store[13], r_store[12]};
    assign raw_fy   = {r_store[15], r_store[14]};

    always_comb begin
        case (r_pos)
            POS_W'(1): hdr_want = r_device_code;
            POS_W'(2): hdr_want = r_system_code;
            default:   hdr_want = r_message_code;
        endcase
    end

    // byte-level parse step
    always_comb begin
        n_pos   = r_pos;
        n_rsum  = r_rsum;
        w_store = 1'b0;
        w_good  = 1'b0;
        w_bad   = 1'b0;
        case (r_pos) inside
            POS_W'(0): begin
                n_pos  = (rx == r_start_byte) ? POS_W'(1) : POS_W'(0);
                n_rsum = (rx == r_start_byte) ? rx : 8'd0;
            end
            [POS_W'(1):POS_W'(3)]: begin
                if (rx == hdr_want) begin
                    n_pos  = r_pos + POS_W'(1);
                    n_rsum = sum_add;
                end else begin
                    n_pos  = (rx == r_start_byte) ? POS_W'(1) : POS_W'(0);
                    n_rsum = (rx == r_start_byte) ? rx : 8'd0;
                end
            end
            POS_SEQ: begin
                n_pos  = POS_LEN;
                n_rsum = sum_add;
            end
            POS_LEN: begin
                if (rx == 8'(PAYLOAD_BYTES)) begin
                    n_pos  = POS_PAYLOAD;
                    n_rsum = sum_add;
                end else begin
                    n_pos  = (rx == r_start_byte) ? POS_W'(1) : POS_W'(0);
                    n_rsum = (rx == r_start_byte) ? rx : 8'd0;
                end
            end
            [POS_PAYLOAD:POS_CHECK - POS_W'(1)]: begin
                w_store = 1'b1;
                n_pos   = r_pos + POS_W'(1);
                n_rsum  = sum_add;
            end
            POS_CHECK: begin
                n_pos  = '0;
                n_rsum = '0;
                w_good = (rx == r_rsum);
                w_bad  = (rx != r_rsum);
            end
            default: begin
                n_pos  = '0;
                n_rsum = '0;
            end
        endcase
    end

    // shift-add step and filter update
    always_comb begin
        n_sum   = r_lo[0] ? (r_hi + MH_W'(r_ma)) : r_hi;
        prod    = {r_hi, r_lo};
        prod_rnd = prod + ROUND_HALF;
        case (r_chan)
            CH_DIST: mem_ext = MA_W'({1'b0, r_dmem});
            CH_FX:   mem_ext = MA_W'(r_fxmem);
            default: mem_ext = MA_W'(r_fymem);
        endcase
        n_mem = mem_ext + prod[MA_W+15:16];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte     <= RST_START_BYTE;
            r_device_code    <= RST_DEVICE_CODE;
            r_system_code    <= RST_SYSTEM_CODE;
            r_message_code   <= RST_MESSAGE_CODE;
            r_filter_gain    <= RST_FILTER_GAIN;
            r_distance_scale <= RST_SCALE;
            r_flow_scale     <= RST_SCALE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_START_BYTE:     r_start_byte     <= i_cfg_data[7:0];
                CFG_DEVICE_CODE:    r_device_code    <= i_cfg_data[7:0];
                CFG_SYSTEM_CODE:    r_system_code    <= i_cfg_data[7:0];
                CFG_MESSAGE_CODE:   r_message_code   <= i_cfg_data[7:0];
                CFG_FILTER_GAIN:    r_filter_gain    <= i_cfg_data[16:0];
                CFG_DISTANCE_SCALE: r_distance_scale <= i_cfg_data;
                CFG_FLOW_SCALE:     r_flow_scale     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && w_store) begin
            r_store[IDX_W'(r_pos - POS_PAYLOAD)] <= rx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_rsum      <= '0;
            r_state     <= ST_IDLE;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_chan      <= CH_DIST;
            r_filt      <= 1'b0;
            r_cnt       <= '0;
            r_dmem      <= '0;
            r_fxmem     <= '0;
            r_fymem     <= '0;
        end else begin
            if (out_acc) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_pos  <= n_pos;
                        r_rsum <= n_rsum;
                        if (w_bad) begin
                            r_out_valid         <= 1'b1;
                            o_frame_status      <= 1'b1;
                            o_system_time       <= '0;
                            o_raw_distance      <= '0;
                            o_signal_strength   <= '0;
                            o_distance_status   <= '0;
                            o_raw_flow_x        <= '0;
                            o_raw_flow_y        <= '0;
                            o_flow_quality      <= '0;
                            o_flow_status       <= '0;
                            o_smoothed_distance <= '0;
                            o_smoothed_flow_x   <= '0;
                            o_smoothed_flow_y   <= '0;
                        end else if (w_good) begin
                            r_busy  <= 1'b1;
                            r_chan  <= CH_DIST;
                            r_filt  <= 1'b0;
                            r_state <= ST_LOAD;
                        end
                    end
                end
                ST_LOAD: begin
                    r_hi  <= '0;
                    r_cnt <= '0;
                    if (r_filt) begin
                        r_ma <= r_x - mem_ext;
                        r_lo <= MB_W'(geff);
                    end else begin
                        case (r_chan)
                            CH_DIST: begin
                                r_ma <= MA_W'({r_store[7], r_store[6],
                                               r_store[5], r_store[4]});
                                r_lo <= r_distance_scale;
                            end
                            CH_FX: begin
                                r_ma <= MA_W'(raw_fx);
                                r_lo <= r_flow_scale;
                            end
                            default: begin
                                r_ma <= MA_W'(raw_fy);
                                r_lo <= r_flow_scale;
                            end
                        endcase
                    end
                    r_state <= ST_RUN;
                end
                ST_RUN: begin
                    r_hi  <= {n_sum[MH_W-1], n_sum[MH_W-1:1]};
                    r_lo  <= {n_sum[0], r_lo[MB_W-1:1]};
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(MB_W - 1)) begin
                        r_state <= ST_POST;
                    end
                end
                ST_POST: begin
                    if (r_filt) begin
                        {r_hi, r_lo} <= prod_rnd;
                        r_state      <= ST_APPLY;
                    end else begin
                        // distance saturates at 48 bits; flow always fits 40
                        if (r_chan == CH_DIST) begin
                            r_x <= (prod[55:DIST_W] != '0) ? MA_W'({DIST_W{1'b1}})
                                                           : MA_W'(prod[DIST_W-1:0]);
                        end else begin
                            r_x <= MA_W'($signed(prod[FLOW_W-1:0]));
                        end
                        r_filt  <= 1'b1;
                        r_state <= ST_LOAD;
                    end
                end
                ST_APPLY: begin
                    r_filt <= 1'b0;
                    case (r_chan)
                        CH_DIST: begin
                            r_dmem  <= n_mem[DIST_W-1:0];
                            r_chan  <= CH_FX;
                            r_state <= ST_LOAD;
                        end
                        CH_FX: begin
                            r_fxmem <= n_mem[FLOW_W-1:0];
                            r_chan  <= CH_FY;
                            r_state <= ST_LOAD;
                        end
                        default: begin
                            r_fymem <= n_mem[FLOW_W-1:0];
                            r_state <= ST_DONE;
                        end
                    endcase
                end
                ST_DONE: begin
                    r_out_valid         <= 1'b1;
                    r_busy              <= 1'b0;
                    r_state             <= ST_IDLE;
                    o_frame_status      <= 1'b0;
                    o_system_time       <= {r_store[3], r_store[2], r_store[1], r_store[0]};
                    o_raw_distance      <= {r_store[7], r_store[6], r_store[5], r_store[4]};
                    o_signal_strength   <= r_store[8];
                    o_distance_status   <= r_store[10];
                    o_raw_flow_x        <= raw_fx;
                    o_raw_flow_y        <= raw_fy;
                    o_flow_quality      <= r_store[16];
                    o_flow_status       <= r_store[17];
                    o_smoothed_distance <= r_dmem;
                    o_smoothed_flow_x   <= r_fxmem;
                    o_smoothed_flow_y   <= r_fymem;
                end
                default: begin
                    r_state <= ST_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> o_in_stall)
        else $error("input taken while arithmetic busy");

    a_run_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_cnt < CNT_W'(MB_W)))
        else $error("multiplier step count overran");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_status) |->
            (o_smoothed_distance == '0 && o_system_time == '0))
        else $error("error result carries data");

    a_idle_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_busy)
        else $error("busy flag stuck in idle");

endmodule
